### rtl/ltsc_pkg.sv
`timescale 1ns / 1ps

package ltsc_pkg;

  // sequence geometry
  localparam int PERIOD        = 255;
  localparam int STORE_BITS    = 510;
  localparam int ADDR_W        = 9;
  localparam int RUN_COUNT     = 14;
  localparam int RUN_W         = 4;
  localparam int RUN_SPAN      = 10;
  localparam int SEEN_DEPTH    = 256;
  localparam int SEEN_W        = 8;

  localparam logic [2:0]        FIXED_TAP     = 3'd7;
  localparam logic [7:0]        ONES_EXPECTED = 8'd128;
  localparam logic [7:0]        LFSR_SEED     = 8'hff;
  localparam logic [ADDR_W-1:0] GEN_LAST      = ADDR_W'(STORE_BITS - 1);
  localparam logic [ADDR_W-1:0] PERIOD_IDX    = ADDR_W'(PERIOD);
  // scan covers every bit that a window or a run starting below PERIOD can touch
  localparam logic [ADDR_W-1:0] SCAN_LAST     = ADDR_W'(PERIOD + 8);
  localparam logic [ADDR_W-1:0] WIN_FIRST     = ADDR_W'(7);
  localparam logic [ADDR_W-1:0] WIN_LAST      = ADDR_W'(PERIOD - 1 + 7);

  // verdict codes
  localparam logic [2:0] VERDICT_PASS    = 3'd0;
  localparam logic [2:0] VERDICT_PERIOD  = 3'd1;
  localparam logic [2:0] VERDICT_ONES    = 3'd2;
  localparam logic [2:0] VERDICT_RUN     = 3'd3;
  localparam logic [2:0] VERDICT_REPEAT  = 3'd4;

  // scan request from the sequencer, one bit address per cycle
  typedef struct packed {
    logic              start;
    logic              valid;
    logic [ADDR_W-1:0] idx;
  } scan_ctl_t;

  // accumulated check results
  typedef struct packed {
    logic                 period_fail;
    logic [7:0]           ones;
    logic [RUN_COUNT-1:0] found;
    logic                 dup;
  } check_stat_t;

  // inner length of each run pattern
  function automatic logic [3:0] run_len(input logic [RUN_W-1:0] r);
    logic [3:0] n;
    case (r)
      4'd0:    n = 4'd1;
      4'd1:    n = 4'd2;
      4'd2:    n = 4'd3;
      4'd3:    n = 4'd4;
      4'd4:    n = 4'd5;
      4'd5:    n = 4'd6;
      4'd6:    n = 4'd8;
      4'd7:    n = 4'd1;
      4'd8:    n = 4'd2;
      4'd9:    n = 4'd3;
      4'd10:   n = 4'd4;
      4'd11:   n = 4'd5;
      4'd12:   n = 4'd6;
      4'd13:   n = 4'd7;
      default: n = 4'd1;
    endcase
    return n;
  endfunction

  // first seven patterns are runs of ones bounded by zeros
  function automatic logic run_kind(input logic [RUN_W-1:0] r);
    return (r < RUN_W'(7));
  endfunction

  // bits of the pattern that take part, newest bit at index 0
  function automatic logic [RUN_SPAN-1:0] run_mask(input logic [RUN_W-1:0] r);
    logic [RUN_SPAN-1:0] m;
    logic [3:0]          n;
    n = run_len(r);
    for (int k = 0; k < RUN_SPAN; k++) begin
      m[k] = (k <= int'(n) + 1);
    end
    return m;
  endfunction

  // pattern value: edge bit, n bits of kind, edge bit
  function automatic logic [RUN_SPAN-1:0] run_pat(input logic [RUN_W-1:0] r);
    logic [RUN_SPAN-1:0] p;
    logic [3:0]          n;
    logic                kd;
    n  = run_len(r);
    kd = run_kind(r);
    for (int k = 0; k < RUN_SPAN; k++) begin
      if (k == 0 || k == int'(n) + 1) begin
        p[k] = ~kd;
      end else if (k <= int'(n)) begin
        p[k] = kd;
      end else begin
        p[k] = 1'b0;
      end
    end
    return p;
  endfunction

endpackage

### rtl/ltsc_bit_store.sv
`timescale 1ns / 1ps

module ltsc_bit_store
  import ltsc_pkg::*;
(
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic              wr_bit,
  input  logic [ADDR_W-1:0] rd_a_addr,
  input  logic [ADDR_W-1:0] rd_b_addr,
  output logic              rd_a_bit_r,
  output logic              rd_b_bit_r
);

  logic mem_r [STORE_BITS];

  // one write port, two registered read ports
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_bit;
    end
    rd_a_bit_r <= mem_r[rd_a_addr];
    rd_b_bit_r <= mem_r[rd_b_addr];
  end

endmodule

### rtl/ltsc_seen_map.sv
`timescale 1ns / 1ps

module ltsc_seen_map
  import ltsc_pkg::*;
(
  input  logic              clk,
  input  logic              clr_en,
  input  logic [SEEN_W-1:0] clr_addr,
  input  logic              set_en,
  input  logic [SEEN_W-1:0] set_addr,
  input  logic [SEEN_W-1:0] rd_addr,
  output logic              rd_bit_r
);

  logic mem_r [SEEN_DEPTH];

  // clear sweep and marking never overlap in time
  always_ff @(posedge clk) begin
    if (clr_en) begin
      mem_r[clr_addr] <= 1'b0;
    end else if (set_en) begin
      mem_r[set_addr] <= 1'b1;
    end
    rd_bit_r <= mem_r[rd_addr];
  end

endmodule

### rtl/ltsc_checker.sv
`timescale 1ns / 1ps

module ltsc_checker
  import ltsc_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  scan_ctl_t         ctl,
  input  logic              bit_a,
  input  logic              bit_b,
  input  logic              seen_bit,
  output logic [SEEN_W-1:0] seen_rd_addr,
  output logic              seen_set_en,
  output logic [SEEN_W-1:0] seen_set_addr,
  output check_stat_t       stat
);

  // stage 1: read data arrives for the bit issued last cycle
  logic              s1_valid_r;
  logic [ADDR_W-1:0] s1_idx_r;
  // stage 2: seen bit arrives for the window looked up last cycle
  logic              s2_valid_r;
  logic [SEEN_W-1:0] s2_win_r;
  logic              s2_fwd_r;

  logic [RUN_SPAN-2:0]  hist_r;
  logic                 period_fail_r;
  logic [7:0]           ones_r;
  logic [RUN_COUNT-1:0] found_r;
  logic                 dup_r;

  logic [RUN_SPAN-1:0]  win_new;
  logic                 in_period;
  logic                 win_valid;
  logic [RUN_COUNT-1:0] hit;

  assign win_new   = {hist_r, bit_a};
  assign in_period = (s1_idx_r < PERIOD_IDX);
  assign win_valid = s1_valid_r && (s1_idx_r >= WIN_FIRST) && (s1_idx_r <= WIN_LAST);

  // one matcher per run pattern on the ten newest bits
  for (genvar r = 0; r < RUN_COUNT; r++) begin : g_run
    localparam logic [RUN_SPAN-1:0] MASK = run_mask(RUN_W'(r));
    localparam logic [RUN_SPAN-1:0] PAT  = run_pat(RUN_W'(r));
    localparam logic [ADDR_W-1:0]   LO   = ADDR_W'(run_len(RUN_W'(r))) + ADDR_W'(1);
    localparam logic [ADDR_W-1:0]   HI   = LO + ADDR_W'(PERIOD - 1);
    assign hit[r] = s1_valid_r && (s1_idx_r >= LO) && (s1_idx_r <= HI)
                    && ((win_new & MASK) == PAT);
  end

  assign seen_rd_addr  = win_new[SEEN_W-1:0];
  assign seen_set_en   = s2_valid_r;
  assign seen_set_addr = s2_win_r;

  // pipeline control
  always_ff @(posedge clk) begin
    if (!rst_n || ctl.start) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= ctl.valid;
      s2_valid_r <= win_valid;
    end
  end

  // stage payload; a window equal to the one being marked misses the write
  always_ff @(posedge clk) begin
    s1_idx_r <= ctl.idx;
    s2_win_r <= win_new[SEEN_W-1:0];
    s2_fwd_r <= s2_valid_r && (win_new[SEEN_W-1:0] == s2_win_r);
    if (s1_valid_r) begin
      hist_r <= win_new[RUN_SPAN-2:0];
    end
  end

  // accumulated results
  always_ff @(posedge clk) begin
    if (!rst_n || ctl.start) begin
      period_fail_r <= 1'b0;
      ones_r        <= 8'd0;
      found_r       <= '0;
      dup_r         <= 1'b0;
    end else begin
      if (s1_valid_r && in_period) begin
        ones_r <= ones_r + {7'd0, bit_a};
        if (bit_a != bit_b) begin
          period_fail_r <= 1'b1;
        end
      end
      found_r <= found_r | hit;
      if (s2_valid_r && (seen_bit || s2_fwd_r)) begin
        dup_r <= 1'b1;
      end
    end
  end

  assign stat.period_fail = period_fail_r;
  assign stat.ones        = ones_r;
  assign stat.found       = found_r;
  assign stat.dup         = dup_r;

endmodule

### rtl/lfsr_tap_sequence_checker.sv
`timescale 1ns / 1ps
// channel | dir | handshake           | payload
// in_     | in  | in_tvalid/in_tready  | in_tdata: tap_second, tap_third, tap_fourth
// out_    | out | out_tvalid/out_tready| out_tdata: verdict, missing_run
//
// one item: 510 generation steps, one per cycle through the tap parity unit into
// the bit store, then a scan over store bits 0 to 263, then a pipeline drain and
// a finish state that forms the verdict
// the seen map is swept clear during the first 256 generation steps
// rst_n is synchronous; in_tready is high only while idle
// a finished verdict waits in the output register; a new item may start meanwhile

module lfsr_tap_sequence_checker
  import ltsc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [2:0] tap_second, [5:3] tap_third, [8:6] tap_fourth
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata   // [2:0] verdict, [6:3] missing_run
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_GEN    = 3'd1;
  localparam logic [2:0] ST_SCAN   = 3'd2;
  localparam logic [2:0] ST_DRAIN  = 3'd3;
  localparam logic [2:0] ST_FINISH = 3'd4;

  logic [2:0]        state_r, state_nxt;
  logic [ADDR_W-1:0] cnt_r, cnt_nxt;
  logic [7:0]        lfsr_r, lfsr_nxt;
  logic [2:0]        tap2_r, tap3_r, tap4_r;
  logic              out_valid_r, out_valid_nxt;
  logic [2:0]        verdict_r;
  logic [RUN_W-1:0]  missing_r;

  logic              accept;
  logic              feedback;
  logic              load_out;
  logic              bit_a, bit_b, seen_bit;
  logic [SEEN_W-1:0] seen_rd_addr, seen_set_addr;
  logic              seen_set_en;
  logic [ADDR_W-1:0] rd_b_addr;
  scan_ctl_t         ctl;
  check_stat_t       stat;
  logic [2:0]        verdict;
  logic [RUN_W-1:0]  missing;

  assign in_tready = (state_r == ST_IDLE);
  assign accept    = in_tvalid && in_tready;

  // tap parity, fixed tap at the top bit
  assign feedback = lfsr_r[FIXED_TAP] ^ lfsr_r[tap2_r] ^ lfsr_r[tap3_r] ^ lfsr_r[tap4_r];
  assign load_out = (state_r == ST_FINISH) && (!out_valid_r || out_tready);

  // sequencer
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    lfsr_nxt  = lfsr_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = ST_GEN;
          cnt_nxt   = '0;
          lfsr_nxt  = LFSR_SEED;
        end
      end
      ST_GEN: begin
        lfsr_nxt = {lfsr_r[6:0], feedback};
        if (cnt_r == GEN_LAST) begin
          state_nxt = ST_SCAN;
          cnt_nxt   = '0;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      ST_SCAN: begin
        if (cnt_r == SCAN_LAST) begin
          state_nxt = ST_DRAIN;
          cnt_nxt   = '0;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      ST_DRAIN: begin
        if (cnt_r[0]) begin
          state_nxt = ST_FINISH;
        end
        cnt_nxt = cnt_r + 1'b1;
      end
      ST_FINISH: begin
        if (load_out) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
      lfsr_r  <= LFSR_SEED;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      lfsr_r  <= lfsr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      tap2_r <= in_tdata[2:0];
      tap3_r <= in_tdata[5:3];
      tap4_r <= in_tdata[8:6];
    end
  end

  // scan request toward the checker
  assign ctl.start = accept;
  assign ctl.valid = (state_r == ST_SCAN);
  assign ctl.idx   = cnt_r;
  assign rd_b_addr = (cnt_r < PERIOD_IDX) ? (cnt_r + PERIOD_IDX) : cnt_r;

  ltsc_bit_store u_store (
    .clk        (clk),
    .wr_en      (state_r == ST_GEN),
    .wr_addr    (cnt_r),
    .wr_bit     (feedback),
    .rd_a_addr  (cnt_r),
    .rd_b_addr  (rd_b_addr),
    .rd_a_bit_r (bit_a),
    .rd_b_bit_r (bit_b)
  );

  ltsc_seen_map u_seen (
    .clk      (clk),
    .clr_en   ((state_r == ST_GEN) && !cnt_r[ADDR_W-1]),
    .clr_addr (cnt_r[SEEN_W-1:0]),
    .set_en   (seen_set_en),
    .set_addr (seen_set_addr),
    .rd_addr  (seen_rd_addr),
    .rd_bit_r (seen_bit)
  );

  ltsc_checker u_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .ctl           (ctl),
    .bit_a         (bit_a),
    .bit_b         (bit_b),
    .seen_bit      (seen_bit),
    .seen_rd_addr  (seen_rd_addr),
    .seen_set_en   (seen_set_en),
    .seen_set_addr (seen_set_addr),
    .stat          (stat)
  );

  // verdict in check order, lowest missing pattern wins
  always_comb begin
    missing = '0;
    for (int i = RUN_COUNT - 1; i >= 0; i--) begin
      if (!stat.found[i]) begin
        missing = RUN_W'(i);
      end
    end
    if (stat.period_fail) begin
      verdict = VERDICT_PERIOD;
      missing = '0;
    end else if (stat.ones != ONES_EXPECTED) begin
      verdict = VERDICT_ONES;
      missing = '0;
    end else if (!(&stat.found)) begin
      verdict = VERDICT_RUN;
    end else if (stat.dup) begin
      verdict = VERDICT_REPEAT;
      missing = '0;
    end else begin
      verdict = VERDICT_PASS;
      missing = '0;
    end
  end

  // output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      verdict_r <= verdict;
      missing_r <= missing;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, missing_r, verdict_r};

  // checks
  a_verdict_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[2:0] == VERDICT_PASS || out_tdata[2:0] == VERDICT_PERIOD
                    || out_tdata[2:0] == VERDICT_ONES || out_tdata[2:0] == VERDICT_RUN
                    || out_tdata[2:0] == VERDICT_REPEAT))
    else $error("verdict code out of range");

  a_missing_only_on_run: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[2:0] != VERDICT_RUN) |-> (out_tdata[6:3] == 4'd0))
    else $error("missing_run set without run verdict");

  a_start_gen: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r == ST_GEN && cnt_r == '0 && lfsr_r == LFSR_SEED))
    else $error("item did not start generation from the seed");

  a_gen_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_GEN) |-> (cnt_r <= GEN_LAST))
    else $error("generation count past the store");

endmodule

### verif/tb.sv
`timescale 1ns / 1ps

module tb;
  import ltsc_pkg::*;

  // one result item: verdict and index of the first missing run
  typedef struct packed {
    logic [2:0] verdict;
    logic [3:0] missing;
  } tap_verdict_t;

  // directed row: three taps, and a typed result where it is obvious
  typedef struct packed {
    logic [2:0]   t2;
    logic [2:0]   t3;
    logic [2:0]   t4;
    logic         known;
    tap_verdict_t res;
  } tap_row_t;

  localparam int DIR_ROWS  = 18;
  localparam int RAND_ITEMS = 580;
  localparam int PHASES    = 4;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [15:0] in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [7:0]  out_tdata;

  tap_verdict_t verdict_q[$];
  int           err_cnt;
  int           send_idle_pct;
  int           stall_pct;
  tap_row_t     dir_rows [DIR_ROWS];
  logic [8:0]   maximal_taps[$];

  lfsr_tap_sequence_checker u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // clock
  initial clk = 1'b0;
  always #4 clk = ~clk;

  // generate 510 bits from an all-ones register and grade the sequence
  function automatic tap_verdict_t predict_verdict(input logic [2:0] t2, input logic [2:0] t3,
                                                   input logic [2:0] t4);
    tap_verdict_t res;
    logic [7:0]   lfsr;
    logic         fb;
    logic         seq [STORE_BITS];
    logic [255:0] seen;
    logic [7:0]   win;
    logic         kind;
    logic         hit;
    logic         ok;
    int           ones;
    int           n;
    res  = '0;
    lfsr = 8'hff;
    for (int i = 0; i < STORE_BITS; i++) begin
      fb     = lfsr[7] ^ lfsr[t2] ^ lfsr[t3] ^ lfsr[t4];
      seq[i] = fb;
      lfsr   = {lfsr[6:0], fb};
    end
    // period
    for (int i = 0; i < PERIOD; i++) begin
      if (seq[i] != seq[i + PERIOD]) res.verdict = VERDICT_PERIOD;
    end
    // ones in one period
    if (res.verdict == VERDICT_PASS) begin
      ones = 0;
      for (int i = 0; i < PERIOD; i++) ones += int'(seq[i]);
      if (ones != 128) res.verdict = VERDICT_ONES;
    end
    // run patterns: indexes 0..6 are ones bounded by zeros, 7..13 the reverse
    for (int r = 0; r < RUN_COUNT; r++) begin
      if (res.verdict == VERDICT_PASS) begin
        kind = (r < 7);
        n    = (r < 6) ? r + 1 : (r == 6) ? 8 : r - 6;
        hit  = 1'b0;
        for (int s = 0; s < PERIOD; s++) begin
          ok = (seq[s] == !kind) && (seq[s + n + 1] == !kind);
          for (int k = 1; k <= n; k++) begin
            if (seq[s + k] != kind) ok = 1'b0;
          end
          if (ok) hit = 1'b1;
        end
        if (!hit) begin
          res.verdict = VERDICT_RUN;
          res.missing = 4'(r);
        end
      end
    end
    // 8-bit windows must all differ
    if (res.verdict == VERDICT_PASS) begin
      seen = '0;
      for (int s = 0; s < PERIOD; s++) begin
        win = '0;
        for (int k = 0; k < 8; k++) win = {win[6:0], seq[s + k]};
        if (seen[win]) res.verdict = VERDICT_REPEAT;
        seen[win] = 1'b1;
      end
    end
    return res;
  endfunction

  // present one item, push its expectation when it is taken
  task automatic send_taps(input logic [2:0] t2, input logic [2:0] t3, input logic [2:0] t4,
                           input tap_verdict_t exp_res);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {7'd0, t4, t3, t2};
    do @(posedge clk); while (!in_tready);
    verdict_q.push_back(exp_res);
    @(negedge clk);
  endtask

  // receiver stalls
  always @(negedge clk) begin
    out_tready <= ($urandom_range(0, 99) >= stall_pct);
  end

  // result checker
  always @(posedge clk) begin
    tap_verdict_t got;
    tap_verdict_t want;
    if (rst_n && out_tvalid && out_tready) begin
      // verdict sits in the low bits, missing_run above it
      got.verdict = out_tdata[2:0];
      got.missing = out_tdata[6:3];
      if (verdict_q.size() == 0) begin
        $display("%0t: unexpected result item, got verdict %0d missing_run %0d",
                 $time, got.verdict, got.missing);
        err_cnt++;
      end else begin
        want = verdict_q.pop_front();
        if (got.verdict != want.verdict) begin
          $display("%0t: verdict mismatch, expected %0d got %0d",
                   $time, want.verdict, got.verdict);
          err_cnt++;
        end
        if (got.missing != want.missing) begin
          $display("%0t: missing_run mismatch, expected %0d got %0d",
                   $time, want.missing, got.missing);
          err_cnt++;
        end
        if (out_tdata[7] !== 1'b0) begin
          $display("%0t: pad bit mismatch, expected 0 got %b", $time, out_tdata[7]);
          err_cnt++;
        end
      end
    end
  end

  // stimulus
  initial begin
    tap_verdict_t v;
    logic [8:0]   code;
    in_tvalid     = 1'b0;
    in_tdata      = '0;
    out_tready    = 1'b0;
    rst_n         = 1'b0;
    err_cnt       = 0;
    send_idle_pct = 0;
    stall_pct     = 0;

    // all taps on bit 7 cancel, so the sequence is all zeros;
    // taps 3,4,5 and 5,4,3 give x^8+x^4+x^3+x^2+1, a primitive polynomial
    dir_rows = '{
      '{3'd7, 3'd7, 3'd7, 1'b1, '{VERDICT_ONES, 4'd0}},
      '{3'd3, 3'd4, 3'd5, 1'b1, '{VERDICT_PASS, 4'd0}},
      '{3'd5, 3'd4, 3'd3, 1'b1, '{VERDICT_PASS, 4'd0}},
      '{3'd0, 3'd0, 3'd0, 1'b0, '0},
      '{3'd1, 3'd2, 3'd3, 1'b0, '0},
      '{3'd1, 3'd2, 3'd4, 1'b0, '0},
      '{3'd0, 3'd1, 3'd6, 1'b0, '0},
      '{3'd2, 3'd2, 3'd5, 1'b0, '0},
      '{3'd5, 3'd2, 3'd2, 1'b0, '0},
      '{3'd6, 3'd6, 3'd6, 1'b0, '0},
      '{3'd0, 3'd7, 3'd0, 1'b0, '0},
      '{3'd7, 3'd7, 3'd0, 1'b0, '0},
      '{3'd4, 3'd4, 3'd4, 1'b0, '0},
      '{3'd1, 3'd1, 3'd1, 1'b0, '0},
      '{3'd2, 3'd3, 3'd7, 1'b0, '0},
      '{3'd6, 3'd5, 3'd4, 1'b0, '0},
      '{3'd3, 3'd3, 3'd3, 1'b0, '0},
      '{3'd7, 3'd0, 3'd7, 1'b0, '0}
    };

    // maximal tap sets, drawn often to reach the run and window checks
    for (int c = 0; c < 512; c++) begin
      code = 9'(c);
      v    = predict_verdict(code[2:0], code[5:3], code[8:6]);
      if (v.verdict == VERDICT_PASS) maximal_taps.push_back(code);
    end

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed table
    for (int i = 0; i < DIR_ROWS; i++) begin
      v = dir_rows[i].known ? dir_rows[i].res
                            : predict_verdict(dir_rows[i].t2, dir_rows[i].t3, dir_rows[i].t4);
      send_taps(dir_rows[i].t2, dir_rows[i].t3, dir_rows[i].t4, v);
    end

    // random phases: none, sender idle, receiver stall, both
    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 48; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 48; end
        default: begin send_idle_pct = 29; stall_pct = 29; end
      endcase
      for (int i = 0; i < RAND_ITEMS / PHASES; i++) begin
        if (maximal_taps.size() != 0 && $urandom_range(0, 99) < 40) begin
          code = maximal_taps[$urandom_range(0, maximal_taps.size() - 1)];
        end else begin
          code = 9'($urandom);
        end
        v = predict_verdict(code[2:0], code[5:3], code[8:6]);
        send_taps(code[2:0], code[5:3], code[8:6], v);
      end
    end
    in_tvalid <= 1'b0;

    // drain, then allow one more item time for stray results
    while (verdict_q.size() != 0) @(posedge clk);
    repeat (1100) @(posedge clk);

    if (err_cnt == 0 && verdict_q.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // watchdog
  initial begin
    #40_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

### files.f
rtl/ltsc_pkg.sv
rtl/ltsc_bit_store.sv
rtl/ltsc_seen_map.sv
rtl/ltsc_checker.sv
rtl/lfsr_tap_sequence_checker.sv
verif/tb.sv
